// ----- hw/rtl/pgvm_pkg.sv -----
package pgvm_pkg;

    // Configuration port geometry: eight registers at 4-byte spacing on a 32-bit data port.
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int REG_IDX_W = 3;

    // Datapath widths.
    localparam int NUM_W     = 36;              // |altitude step| * 1e6 and the quotient
    localparam int DEN_W     = 32;              // time step in microseconds
    localparam int MB_W      = 16;              // serial multiplier operand (a register)
    localparam int PROD_W    = NUM_W + MB_W;    // serial multiplier product
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);
    localparam int MUL_CNT_W = $clog2(MB_W + 1);
    localparam int UP_W      = 24;
    localparam int PL_W      = 17;

    localparam logic [19:0] US_PER_S = 20'd1000000;

    // Vertical saturation limits.
    localparam logic [UP_W-1:0] UP_MAX = 24'h7FFFFF;
    localparam logic [UP_W-1:0] DN_MAX = 24'h800000;

    // Register reset values.
    localparam logic [15:0] RST_CURV_LIMIT    = 16'd5243;
    localparam logic [15:0] RST_MIN_POINTS    = 16'd500;
    localparam logic [15:0] RST_PLANE_GAIN    = 16'd205;
    localparam logic [15:0] RST_VERTICAL_GAIN = 16'd205;
    localparam logic [15:0] RST_UP_BOOST      = 16'd6144;
    localparam logic [14:0] RST_X_DEADZONE    = 15'd1638;
    localparam logic [14:0] RST_Y_DEADZONE    = 15'd1638;
    localparam logic [14:0] RST_RATE_DEADZONE = 15'd50;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_CURV_LIMIT    = 3'd0,
        REG_MIN_POINTS    = 3'd1,
        REG_PLANE_GAIN    = 3'd2,
        REG_VERTICAL_GAIN = 3'd3,
        REG_UP_BOOST      = 3'd4,
        REG_X_DEADZONE    = 3'd5,
        REG_Y_DEADZONE    = 3'd6,
        REG_RATE_DEADZONE = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] curv_limit;
        logic [15:0] min_points;
        logic [15:0] plane_gain;
        logic [15:0] vertical_gain;
        logic [15:0] up_boost;
        logic [14:0] x_deadzone;
        logic [14:0] y_deadzone;
        logic [14:0] rate_deadzone;
    } cfg_t;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PREP  = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_MULG  = 7'b0001000,
        S_MULB  = 7'b0010000,
        S_WAITP = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

endpackage

// ----- hw/rtl/pgvm_if.sv -----
// Input channel: one fitted hand-plane measurement per item.
interface pgvm_in_if;
    logic               valid;
    logic               ready;
    logic        [15:0] curvature;
    logic        [15:0] point_count;
    logic        [31:0] stamp_us;
    logic signed [15:0] altitude;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;

    modport source (
        output valid, curvature, point_count, stamp_us, altitude,
               normal_x, normal_y, normal_z,
        input  ready
    );
    modport sink (
        input  valid, curvature, point_count, stamp_us, altitude,
               normal_x, normal_y, normal_z,
        output ready
    );
endinterface

// Output channel: one velocity command per item.
interface pgvm_out_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] vel_forward;
    logic signed [16:0] vel_right;
    logic signed [23:0] vel_up;
    logic               accepted;

    modport source (
        output valid, vel_forward, vel_right, vel_up, accepted,
        input  ready
    );
    modport sink (
        input  valid, vel_forward, vel_right, vel_up, accepted,
        output ready
    );
endinterface

// ----- hw/rtl/pgvm_cfg.sv -----
module pgvm_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pgvm_pkg::ADDR_W-1:0]   paddr,
    input  logic [pgvm_pkg::DATA_W-1:0]   pwdata,
    output logic [pgvm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output pgvm_pkg::cfg_t                cfg
);

    pgvm_pkg::cfg_t   cfg_reg;
    pgvm_pkg::reg_idx_t idx;
    logic             wr_en;

    assign pready = 1'b1;
    assign idx    = pgvm_pkg::reg_idx_t'(paddr[pgvm_pkg::ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Register file, written in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.curv_limit    <= pgvm_pkg::RST_CURV_LIMIT;
            cfg_reg.min_points    <= pgvm_pkg::RST_MIN_POINTS;
            cfg_reg.plane_gain    <= pgvm_pkg::RST_PLANE_GAIN;
            cfg_reg.vertical_gain <= pgvm_pkg::RST_VERTICAL_GAIN;
            cfg_reg.up_boost      <= pgvm_pkg::RST_UP_BOOST;
            cfg_reg.x_deadzone    <= pgvm_pkg::RST_X_DEADZONE;
            cfg_reg.y_deadzone    <= pgvm_pkg::RST_Y_DEADZONE;
            cfg_reg.rate_deadzone <= pgvm_pkg::RST_RATE_DEADZONE;
        end
        else if (wr_en)
        begin
            unique case (idx)
                pgvm_pkg::REG_CURV_LIMIT:    cfg_reg.curv_limit    <= pwdata[15:0];
                pgvm_pkg::REG_MIN_POINTS:    cfg_reg.min_points    <= pwdata[15:0];
                pgvm_pkg::REG_PLANE_GAIN:    cfg_reg.plane_gain    <= pwdata[15:0];
                pgvm_pkg::REG_VERTICAL_GAIN: cfg_reg.vertical_gain <= pwdata[15:0];
                pgvm_pkg::REG_UP_BOOST:      cfg_reg.up_boost      <= pwdata[15:0];
                pgvm_pkg::REG_X_DEADZONE:    cfg_reg.x_deadzone    <= pwdata[14:0];
                pgvm_pkg::REG_Y_DEADZONE:    cfg_reg.y_deadzone    <= pwdata[14:0];
                pgvm_pkg::REG_RATE_DEADZONE: cfg_reg.rate_deadzone <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    // Read-back mux.
    always_comb
    begin
        unique case (idx)
            pgvm_pkg::REG_CURV_LIMIT:    prdata = 32'(cfg_reg.curv_limit);
            pgvm_pkg::REG_MIN_POINTS:    prdata = 32'(cfg_reg.min_points);
            pgvm_pkg::REG_PLANE_GAIN:    prdata = 32'(cfg_reg.plane_gain);
            pgvm_pkg::REG_VERTICAL_GAIN: prdata = 32'(cfg_reg.vertical_gain);
            pgvm_pkg::REG_UP_BOOST:      prdata = 32'(cfg_reg.up_boost);
            pgvm_pkg::REG_X_DEADZONE:    prdata = 32'(cfg_reg.x_deadzone);
            pgvm_pkg::REG_Y_DEADZONE:    prdata = 32'(cfg_reg.y_deadzone);
            pgvm_pkg::REG_RATE_DEADZONE: prdata = 32'(cfg_reg.rate_deadzone);
            default:                     prdata = '0;
        endcase
    end

endmodule

// ----- hw/rtl/pgvm_sdiv.sv -----
// Restoring divider, one quotient bit per cycle.
module pgvm_sdiv (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [pgvm_pkg::NUM_W-1:0]   num,
    input  logic [pgvm_pkg::DEN_W-1:0]   den,
    output logic                         busy,
    output logic [pgvm_pkg::NUM_W-1:0]   quo
);

    logic [pgvm_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [pgvm_pkg::DEN_W-1:0]     rem_reg;
    logic [pgvm_pkg::DEN_W-1:0]     rem_next;
    logic [pgvm_pkg::DEN_W-1:0]     den_reg;
    logic [pgvm_pkg::NUM_W-1:0]     q_reg;
    logic [pgvm_pkg::NUM_W-1:0]     q_next;
    logic [pgvm_pkg::DEN_W:0]       shifted;
    logic [pgvm_pkg::DEN_W:0]       diff;
    logic                           ge;

    assign busy = (cnt_reg != '0);
    assign quo  = q_reg;

    // One trial subtraction: numerator bits leave at the top of q_reg,
    // quotient bits enter at the bottom.
    always_comb
    begin
        shifted  = {rem_reg, q_reg[pgvm_pkg::NUM_W-1]};
        ge       = (shifted >= {1'b0, den_reg});
        diff     = shifted - {1'b0, den_reg};
        rem_next = ge ? diff[pgvm_pkg::DEN_W-1:0] : shifted[pgvm_pkg::DEN_W-1:0];
        q_next   = {q_reg[pgvm_pkg::NUM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= pgvm_pkg::DIV_CNT_W'(pgvm_pkg::NUM_W);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - pgvm_pkg::DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            q_reg   <= num;
            den_reg <= den;
        end
        else if (busy)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

endmodule

// ----- hw/rtl/pgvm_smul.sv -----
// Shift-add multiplier, one multiplier bit per cycle, LSB first.
module pgvm_smul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pgvm_pkg::NUM_W-1:0]    a,
    input  logic [pgvm_pkg::MB_W-1:0]     b,
    output logic                          busy,
    output logic [pgvm_pkg::PROD_W-1:0]   prod
);

    logic [pgvm_pkg::MUL_CNT_W-1:0] cnt_reg;
    logic [pgvm_pkg::NUM_W-1:0]     a_reg;
    logic [pgvm_pkg::NUM_W-1:0]     hi_reg;
    logic [pgvm_pkg::MB_W-1:0]      lo_reg;
    logic [pgvm_pkg::NUM_W:0]       sum;

    assign busy = (cnt_reg != '0);
    assign prod = {hi_reg, lo_reg};

    // Partial sum for the current multiplier bit.
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= pgvm_pkg::MUL_CNT_W'(pgvm_pkg::MB_W);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - pgvm_pkg::MUL_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end
        else if (busy)
        begin
            hi_reg <= sum[pgvm_pkg::NUM_W:1];
            lo_reg <= {sum[0], lo_reg[pgvm_pkg::MB_W-1:1]};
        end
    end

endmodule

// ----- hw/rtl/plane_gesture_velocity_mapper.sv -----
// Maps one fitted hand-plane measurement to one velocity command. A
// measurement counts when its curvature is below the curvature limit and its
// point count exceeds min_points; otherwise the command is all zeros and the
// stored altitude and timestamp stay as they were. The planar command takes
// the larger normal component past its deadzone, scaled by plane_gain. The
// vertical command is the altitude rate in mm/s (from the previous counted
// measurement), scaled by vertical_gain, boosted by up_boost when upward and
// saturated to 24 bits. One item is in work at a time, and a new item is
// taken while the previous command still waits on the output. The rate
// divider resolves one of 36 quotient bits per cycle; the vertical gain and
// up_boost steps share one shift-add multiplier, and the planar gain has its
// own. A rejected item skips the divider and multipliers; one with no usable
// time step skips the divider.
module plane_gesture_velocity_mapper (
    input  logic                          clk,
    input  logic                          rst_n,
    pgvm_in_if.sink                       in_ch,
    pgvm_out_if.source                    out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pgvm_pkg::ADDR_W-1:0]   paddr,
    input  logic [pgvm_pkg::DATA_W-1:0]   pwdata,
    output logic [pgvm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    pgvm_pkg::cfg_t   cfg;
    pgvm_pkg::state_t state_reg;
    pgvm_pkg::state_t state_next;

    // History of the last counted measurement.
    logic               have_prev_reg;
    logic        [31:0] prev_stamp_reg;
    logic signed [15:0] prev_alt_reg;

    // Per-item working registers.
    logic                     ok_reg;
    logic                     rate_reg;
    logic [31:0]              dt_reg;
    logic [16:0]              dalt_reg;
    logic [16:0]              pl_mag_reg;
    logic                     pl_neg_reg;
    logic                     right_reg;
    logic                     fwd_reg;
    logic [pgvm_pkg::UP_W-1:0] up_reg;
    logic [pgvm_pkg::UP_W-1:0] up_next;
    logic                     up_load;

    // Output register.
    logic                      out_valid_reg;
    logic [pgvm_pkg::PL_W-1:0] vel_fwd_reg;
    logic [pgvm_pkg::PL_W-1:0] vel_right_reg;
    logic [pgvm_pkg::UP_W-1:0] vel_up_reg;
    logic                      accepted_reg;

    // Accept-time decode.
    logic        in_acc;
    logic        ok_now;
    logic [31:0] dt_now;
    logic [16:0] dalt_now;
    logic        nz_pos;
    logic [16:0] nx_ext;
    logic [16:0] ny_ext;
    logic [16:0] ay;
    logic [16:0] ax;
    logic        yy_neg;
    logic        xx_neg;
    logic        right_now;
    logic        fwd_now;

    // Serial units.
    logic [15:0]                   dmag;
    logic [pgvm_pkg::NUM_W-1:0]    num_now;
    logic                          div_start;
    logic                          div_busy;
    logic [pgvm_pkg::NUM_W-1:0]    quo;
    logic                          vmul_start;
    logic [pgvm_pkg::NUM_W-1:0]    vmul_a;
    logic [pgvm_pkg::MB_W-1:0]     vmul_b;
    logic                          vmul_busy;
    logic [pgvm_pkg::PROD_W-1:0]   vprod;
    logic                          pmul_start;
    logic                          pmul_busy;
    logic [pgvm_pkg::PROD_W-1:0]   pprod;
    logic [43:0]                   p_gain;
    logic [39:0]                   p_boost;
    logic [16:0]                   pl_val;
    logic                          out_load;

    pgvm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pgvm_sdiv u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_now),
        .den   (dt_reg),
        .busy  (div_busy),
        .quo   (quo)
    );

    pgvm_smul u_vmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (vmul_start),
        .a     (vmul_a),
        .b     (vmul_b),
        .busy  (vmul_busy),
        .prod  (vprod)
    );

    pgvm_smul u_pmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (pmul_start),
        .a     (pgvm_pkg::NUM_W'(pl_mag_reg)),
        .b     (cfg.plane_gain),
        .busy  (pmul_busy),
        .prod  (pprod)
    );

    assign in_ch.ready = (state_reg == pgvm_pkg::S_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;

    // Checks, time step, altitude step and planar axis choice on acceptance.
    always_comb
    begin
        ok_now    = (in_ch.curvature < cfg.curv_limit) &&
                    (in_ch.point_count > cfg.min_points);
        dt_now    = in_ch.stamp_us - prev_stamp_reg;
        dalt_now  = {in_ch.altitude[15], in_ch.altitude} - {prev_alt_reg[15], prev_alt_reg};
        nz_pos    = !in_ch.normal_z[15] && (in_ch.normal_z != '0);
        nx_ext    = {in_ch.normal_x[15], in_ch.normal_x};
        ny_ext    = {in_ch.normal_y[15], in_ch.normal_y};
        ay        = in_ch.normal_x[15] ? (17'd0 - nx_ext) : nx_ext;
        ax        = in_ch.normal_y[15] ? (17'd0 - ny_ext) : ny_ext;
        yy_neg    = in_ch.normal_x[15] ^ !nz_pos;
        xx_neg    = in_ch.normal_y[15] ^ !nz_pos;
        right_now = (ay > ax) && (ay > {2'b00, cfg.y_deadzone});
        fwd_now   = !right_now && (ax > {2'b00, cfg.x_deadzone});
    end

    // Numerator of the rate: |altitude step| times microseconds per second.
    assign dmag    = dalt_reg[16] ? 16'(17'd0 - dalt_reg) : dalt_reg[15:0];
    assign num_now = pgvm_pkg::NUM_W'(dmag) * pgvm_pkg::NUM_W'(pgvm_pkg::US_PER_S);

    assign p_gain  = vprod[pgvm_pkg::PROD_W-1:8];
    assign p_boost = vprod[pgvm_pkg::PROD_W-1:12];

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        pmul_start = 1'b0;
        vmul_start = 1'b0;
        vmul_a     = quo;
        vmul_b     = cfg.vertical_gain;
        up_load    = 1'b0;
        up_next    = '0;
        out_load   = 1'b0;
        unique case (state_reg)
            pgvm_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = pgvm_pkg::S_PREP;
                end
            end
            pgvm_pkg::S_PREP:
            begin
                up_load    = 1'b1;
                pmul_start = ok_reg;
                div_start  = ok_reg && rate_reg;
                if (!ok_reg)
                begin
                    state_next = pgvm_pkg::S_DONE;
                end
                else if (rate_reg)
                begin
                    state_next = pgvm_pkg::S_DIV;
                end
                else
                begin
                    state_next = pgvm_pkg::S_WAITP;
                end
            end
            pgvm_pkg::S_DIV:
            begin
                if (!div_busy)
                begin
                    if (quo > pgvm_pkg::NUM_W'(cfg.rate_deadzone))
                    begin
                        vmul_start = 1'b1;
                        state_next = pgvm_pkg::S_MULG;
                    end
                    else
                    begin
                        state_next = pgvm_pkg::S_WAITP;
                    end
                end
            end
            pgvm_pkg::S_MULG:
            begin
                if (!vmul_busy)
                begin
                    if (!dalt_reg[16])
                    begin
                        // Upward: clamping the operand keeps the saturated result.
                        vmul_a     = (p_gain[43:36] != '0) ? '1 : p_gain[35:0];
                        vmul_b     = cfg.up_boost;
                        vmul_start = 1'b1;
                        state_next = pgvm_pkg::S_MULB;
                    end
                    else
                    begin
                        up_load    = 1'b1;
                        up_next    = 24'd0 - ((p_gain > 44'(pgvm_pkg::DN_MAX)) ?
                                              pgvm_pkg::DN_MAX : p_gain[23:0]);
                        state_next = pgvm_pkg::S_WAITP;
                    end
                end
            end
            pgvm_pkg::S_MULB:
            begin
                if (!vmul_busy)
                begin
                    up_load    = 1'b1;
                    up_next    = (p_boost > 40'(pgvm_pkg::UP_MAX)) ?
                                 pgvm_pkg::UP_MAX : p_boost[23:0];
                    state_next = pgvm_pkg::S_WAITP;
                end
            end
            pgvm_pkg::S_WAITP:
            begin
                if (!pmul_busy)
                begin
                    state_next = pgvm_pkg::S_DONE;
                end
            end
            pgvm_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load   = 1'b1;
                    state_next = pgvm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pgvm_pkg::S_IDLE;
            end
        endcase
    end

    // Signed planar value from the scaled magnitude.
    assign pl_val = pl_neg_reg ? (17'd0 - pprod[31:15]) : pprod[31:15];

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pgvm_pkg::S_IDLE;
            have_prev_reg  <= 1'b0;
            prev_stamp_reg <= '0;
            prev_alt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc && ok_now)
            begin
                have_prev_reg  <= 1'b1;
                prev_stamp_reg <= in_ch.stamp_us;
                prev_alt_reg   <= in_ch.altitude;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item payload registers.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            ok_reg     <= ok_now;
            rate_reg   <= have_prev_reg && (dt_now != '0);
            dt_reg     <= dt_now;
            dalt_reg   <= dalt_now;
            pl_mag_reg <= right_now ? ay : ax;
            pl_neg_reg <= right_now ? yy_neg : xx_neg;
            right_reg  <= right_now;
            fwd_reg    <= fwd_now;
        end
        if (up_load)
        begin
            up_reg <= up_next;
        end
        if (out_load)
        begin
            vel_fwd_reg   <= (ok_reg && fwd_reg) ? pl_val : '0;
            vel_right_reg <= (ok_reg && right_reg) ? pl_val : '0;
            vel_up_reg    <= ok_reg ? up_reg : '0;
            accepted_reg  <= ok_reg;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.vel_forward = vel_fwd_reg;
    assign out_ch.vel_right   = vel_right_reg;
    assign out_ch.vel_up      = vel_up_reg;
    assign out_ch.accepted    = accepted_reg;

`ifndef ASSERT_OFF
    // A rejected measurement carries no velocity at all.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.accepted |->
            out_ch.vel_forward == '0 && out_ch.vel_right == '0 && out_ch.vel_up == '0)
        else $error("rejected item carries a nonzero velocity");

    // At most one planar axis is driven.
    a_one_axis: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.vel_forward == '0 || out_ch.vel_right == '0)
        else $error("both planar axes driven");

    // The serial units are quiet whenever a new item may enter.
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pgvm_pkg::S_IDLE |-> !div_busy && !vmul_busy && !pmul_busy)
        else $error("serial unit busy while idle");

    // A counted measurement becomes the history for the next one.
    a_history: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && ok_now |=> have_prev_reg && prev_stamp_reg == $past(in_ch.stamp_us))
        else $error("history not updated after a counted measurement");
`endif

endmodule

// ----- sim/tb_plane_gesture_velocity_mapper.sv -----
module tb_plane_gesture_velocity_mapper;

    // One fitted hand-plane measurement as driven on the input channel.
    typedef struct {
        logic        [15:0] curvature;
        logic        [15:0] point_count;
        logic        [31:0] stamp_us;
        logic signed [15:0] altitude;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
    } plane_meas_t;

    // One velocity command as seen on the output channel.
    typedef struct {
        logic signed [16:0] vel_forward;
        logic signed [16:0] vel_right;
        logic signed [23:0] vel_up;
        logic               accepted;
    } vel_cmd_t;

    localparam int HOLD_AT        = 120;
    localparam int HOLD_LEN       = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    logic clk = 1'b0;
    logic rst_n;

    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [pgvm_pkg::ADDR_W-1:0]   paddr;
    logic [pgvm_pkg::DATA_W-1:0]   pwdata;
    logic [pgvm_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    pgvm_in_if  in_ch ();
    pgvm_out_if out_ch ();

    plane_gesture_velocity_mapper uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Stimulus waiting to be driven and commands waiting to come out.
    plane_meas_t measurement_queue[$];
    vel_cmd_t    expected_commands[$];

    // Shadow of the configuration registers and of the altitude history.
    pgvm_pkg::cfg_t     cfg_shadow;
    logic               have_prev;
    logic signed [15:0] prev_altitude;
    logic        [31:0] prev_stamp;

    // Running timestamp and altitude for well-formed measurement sequences.
    logic        [31:0] gen_stamp;
    logic signed [15:0] gen_alt;

    logic in_taken     = 1'b0;
    logic calm         = 1'b0;
    logic hold_done    = 1'b0;
    int   items_in     = 0;
    int   stall_cycles = 0;
    int   hold_left    = 0;
    int   error_count  = 0;

    always #2 clk = ~clk;

    // Planar scaling: Q1.15 axis value times the Q8.8 gain, truncated toward zero.
    function automatic logic signed [16:0] scale_planar(int axis);
        longint mag;
        mag = (axis < 0) ? -longint'(axis) : longint'(axis);
        mag = (mag * longint'(cfg_shadow.plane_gain)) >>> 15;
        return axis < 0 ? -17'(mag) : 17'(mag);
    endfunction

    // Works out the command for one accepted measurement and advances the history.
    function automatic vel_cmd_t predict_command(plane_meas_t m);
        vel_cmd_t    cmd;
        logic [31:0] dt;
        int          dalt;
        int          right_axis;
        int          fwd_axis;
        int          right_mag;
        int          fwd_mag;
        logic [63:0] rate;
        logic [63:0] scaled;
        cmd.vel_forward = '0;
        cmd.vel_right   = '0;
        cmd.vel_up      = '0;
        cmd.accepted    = 1'b0;
        if (!(m.curvature < cfg_shadow.curv_limit && m.point_count > cfg_shadow.min_points))
            return cmd;
        cmd.accepted = 1'b1;

        // Vertical rate from the previous accepted measurement.
        if (have_prev)
        begin
            dt   = m.stamp_us - prev_stamp;
            dalt = int'(m.altitude) - int'(prev_altitude);
            if (dt != 32'd0)
            begin
                rate = (64'(dalt < 0 ? -dalt : dalt) * 64'd1000000) / 64'(dt);
                if (rate > 64'(cfg_shadow.rate_deadzone))
                begin
                    scaled = (rate * 64'(cfg_shadow.vertical_gain)) >> 8;
                    if (dalt > 0)
                    begin
                        scaled = (scaled * 64'(cfg_shadow.up_boost)) >> 12;
                        if (scaled > 64'(pgvm_pkg::UP_MAX))
                            scaled = 64'(pgvm_pkg::UP_MAX);
                        cmd.vel_up = scaled[23:0];
                    end
                    else
                    begin
                        if (scaled > 64'(pgvm_pkg::DN_MAX))
                            scaled = 64'(pgvm_pkg::DN_MAX);
                        cmd.vel_up = -scaled[23:0];
                    end
                end
            end
        end

        // Planar axes are swapped from the normal and flipped when z is not positive.
        right_axis = (m.normal_z > 0) ? int'(m.normal_x) : -int'(m.normal_x);
        fwd_axis   = (m.normal_z > 0) ? int'(m.normal_y) : -int'(m.normal_y);
        right_mag  = right_axis < 0 ? -right_axis : right_axis;
        fwd_mag    = fwd_axis < 0 ? -fwd_axis : fwd_axis;
        if (right_mag > fwd_mag && right_mag > int'(cfg_shadow.y_deadzone))
            cmd.vel_right = scale_planar(right_axis);
        else if (fwd_mag > int'(cfg_shadow.x_deadzone))
            cmd.vel_forward = scale_planar(fwd_axis);

        prev_stamp    = m.stamp_us;
        prev_altitude = m.altitude;
        have_prev     = 1'b1;
        return cmd;
    endfunction

    // Mostly well-formed measurements that pass the checks, the rest pure noise.
    function automatic plane_meas_t gen_measurement();
        plane_meas_t m;
        int          pick;
        logic [31:0] dt;
        m.curvature   = 16'($urandom);
        m.point_count = 16'($urandom);
        m.stamp_us    = $urandom;
        m.altitude    = 16'($urandom);
        m.normal_x    = 16'($urandom);
        m.normal_y    = 16'($urandom);
        m.normal_z    = 16'($urandom);
        if ($urandom_range(0, 99) < 75)
        begin
            if (cfg_shadow.curv_limit != 16'd0)
                m.curvature = 16'($urandom_range(0, int'(cfg_shadow.curv_limit) - 1));
            if (cfg_shadow.min_points != 16'hFFFF)
                m.point_count = 16'($urandom_range(int'(cfg_shadow.min_points) + 1, 65535));
            pick = $urandom_range(0, 9);
            case (pick)
                0: dt = 32'd0;
                1: dt = $urandom_range(1, 40);
                2: dt = $urandom;
                default: dt = $urandom_range(5000, 100000);
            endcase
            gen_stamp  = gen_stamp + dt;
            m.stamp_us = gen_stamp;
            if ($urandom_range(0, 9) != 0)
                gen_alt = 16'(int'(gen_alt) + int'($urandom_range(0, 600)) - 300);
            else
                gen_alt = 16'($urandom);
            m.altitude = gen_alt;
            // Keep some normals near the deadzones.
            if ($urandom_range(0, 2) == 0)
            begin
                m.normal_x = 16'(int'($urandom_range(0, 8000)) - 4000);
                m.normal_y = 16'(int'($urandom_range(0, 8000)) - 4000);
            end
        end
        return m;
    endfunction

    task automatic add_item(logic [15:0] curvature, logic [15:0] point_count,
                            logic [31:0] stamp_us, logic signed [15:0] altitude,
                            logic signed [15:0] normal_x, logic signed [15:0] normal_y,
                            logic signed [15:0] normal_z);
        plane_meas_t m;
        m.curvature   = curvature;
        m.point_count = point_count;
        m.stamp_us    = stamp_us;
        m.altitude    = altitude;
        m.normal_x    = normal_x;
        m.normal_y    = normal_y;
        m.normal_z    = normal_z;
        measurement_queue.push_back(m);
    endtask

    // Writes one register, updates the shadow and reads the register back.
    task automatic cfg_write(pgvm_pkg::reg_idx_t idx, logic [31:0] value);
        logic [31:0] stored;
        stored = (idx inside {pgvm_pkg::REG_X_DEADZONE, pgvm_pkg::REG_Y_DEADZONE,
                              pgvm_pkg::REG_RATE_DEADZONE}) ?
                 (value & 32'h7FFF) : (value & 32'hFFFF);
        case (idx)
            pgvm_pkg::REG_CURV_LIMIT:    cfg_shadow.curv_limit    = stored[15:0];
            pgvm_pkg::REG_MIN_POINTS:    cfg_shadow.min_points    = stored[15:0];
            pgvm_pkg::REG_PLANE_GAIN:    cfg_shadow.plane_gain    = stored[15:0];
            pgvm_pkg::REG_VERTICAL_GAIN: cfg_shadow.vertical_gain = stored[15:0];
            pgvm_pkg::REG_UP_BOOST:      cfg_shadow.up_boost      = stored[15:0];
            pgvm_pkg::REG_X_DEADZONE:    cfg_shadow.x_deadzone    = stored[14:0];
            pgvm_pkg::REG_Y_DEADZONE:    cfg_shadow.y_deadzone    = stored[14:0];
            pgvm_pkg::REG_RATE_DEADZONE: cfg_shadow.rate_deadzone = stored[14:0];
            default: ;
        endcase

        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);

        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== stored)
        begin
            $display("%0t: register %s read back: expected %h, actual %h",
                     $time, idx.name(), stored, prdata);
            error_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Returns once every queued item has gone in and every command has come out.
    task automatic wait_idle();
        while (measurement_queue.size() != 0 || in_ch.valid || expected_commands.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic check_field(string field, logic signed [23:0] want, logic signed [23:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            error_count++;
        end
    endtask

    // Input driver: offers the next item once the current one has been taken.
    always @(negedge clk)
    begin : drive_items
        plane_meas_t next_item;
        if (rst_n && (!in_ch.valid || in_taken))
        begin
            if (measurement_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 18))
            begin
                next_item = measurement_queue.pop_front();
                in_ch.valid       <= 1'b1;
                in_ch.curvature   <= next_item.curvature;
                in_ch.point_count <= next_item.point_count;
                in_ch.stamp_us    <= next_item.stamp_us;
                in_ch.altitude    <= next_item.altitude;
                in_ch.normal_x    <= next_item.normal_x;
                in_ch.normal_y    <= next_item.normal_y;
                in_ch.normal_z    <= next_item.normal_z;
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Output ready: random stalls, plus one long hold-off so that the block backs up.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (items_in == HOLD_AT && !hold_done)
        begin
            out_ch.ready <= 1'b0;
            hold_left    <= HOLD_LEN;
            hold_done    <= 1'b1;
        end
        else
        begin
            out_ch.ready <= calm || ($urandom_range(0, 99) >= 18);
        end
    end

    // Monitor: checks each command, predicts each accepted item, counts dead cycles.
    always @(posedge clk)
    begin : watch_channels
        vel_cmd_t    want_cmd;
        plane_meas_t seen;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_commands.size() == 0)
                begin
                    $display("%0t: unexpected command: expected none, actual %0d %0d %0d %0d",
                             $time, out_ch.vel_forward, out_ch.vel_right, out_ch.vel_up,
                             out_ch.accepted);
                    error_count++;
                end
                else
                begin
                    want_cmd = expected_commands.pop_front();
                    check_field("vel_forward", want_cmd.vel_forward, out_ch.vel_forward);
                    check_field("vel_right", want_cmd.vel_right, out_ch.vel_right);
                    check_field("vel_up", want_cmd.vel_up, out_ch.vel_up);
                    check_field("accepted", {23'd0, want_cmd.accepted}, {23'd0, out_ch.accepted});
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                seen.curvature   = in_ch.curvature;
                seen.point_count = in_ch.point_count;
                seen.stamp_us    = in_ch.stamp_us;
                seen.altitude    = in_ch.altitude;
                seen.normal_x    = in_ch.normal_x;
                seen.normal_y    = in_ch.normal_y;
                seen.normal_z    = in_ch.normal_z;
                expected_commands.push_back(predict_command(seen));
                items_in <= items_in + 1;
            end
            if ((measurement_queue.size() != 0 || in_ch.valid || expected_commands.size() != 0)
                && !(in_ch.valid && in_ch.ready) && !(out_ch.valid && out_ch.ready))
                stall_cycles <= stall_cycles + 1;
            else
                stall_cycles <= 0;
        end
        in_taken <= rst_n && in_ch.valid && in_ch.ready;
    end

    // Watchdog: ends the run when nothing moves for too long.
    initial
    begin
        while (stall_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("%0t: timeout, no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("** plane_gesture_velocity_mapper: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.curvature   = '0;
        in_ch.point_count = '0;
        in_ch.stamp_us    = '0;
        in_ch.altitude    = '0;
        in_ch.normal_x    = '0;
        in_ch.normal_y    = '0;
        in_ch.normal_z    = '0;
        out_ch.ready      = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        cfg_shadow.curv_limit    = pgvm_pkg::RST_CURV_LIMIT;
        cfg_shadow.min_points    = pgvm_pkg::RST_MIN_POINTS;
        cfg_shadow.plane_gain    = pgvm_pkg::RST_PLANE_GAIN;
        cfg_shadow.vertical_gain = pgvm_pkg::RST_VERTICAL_GAIN;
        cfg_shadow.up_boost      = pgvm_pkg::RST_UP_BOOST;
        cfg_shadow.x_deadzone    = pgvm_pkg::RST_X_DEADZONE;
        cfg_shadow.y_deadzone    = pgvm_pkg::RST_Y_DEADZONE;
        cfg_shadow.rate_deadzone = pgvm_pkg::RST_RATE_DEADZONE;
        have_prev     = 1'b0;
        prev_altitude = '0;
        prev_stamp    = '0;
        gen_stamp     = 32'd5000000;
        gen_alt       = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed items at the reset settings.
        // Rejections: curvature at the limit, count at the limit, extreme fields.
        add_item(16'd5243, 16'd1000, 32'd100, 16'sd10, 16'sd20000, 16'sd0, 16'sd1);
        add_item(16'd0, 16'd500, 32'd100, 16'sd10, 16'sd20000, 16'sd0, 16'sd1);
        add_item(16'hFFFF, 16'd1000, 32'd100, 16'sd10, 16'sd20000, 16'sd0, 16'sd1);
        add_item(16'd0, 16'd0, 32'd100, 16'sd10, 16'sd20000, 16'sd0, 16'sd1);
        // First accepted item has no rate; then a zero time step.
        add_item(16'd0, 16'hFFFF, 32'd1000, 16'sd100, 16'sh7FFF, 16'sd0, 16'sd1);
        add_item(16'd5242, 16'd501, 32'd1000, 16'sd300, 16'sd0, 16'sh7FFF, 16'sd1);
        // Saturation upward and downward over a one-microsecond step.
        add_item(16'd0, 16'd1000, 32'd1001, 16'sh7FFF, 16'sd0, 16'sd0, 16'sd0);
        add_item(16'd0, 16'd1000, 32'd1002, -16'sd32768, 16'sd0, 16'sd0, 16'sd0);
        // Rate exactly at the deadzone, then one above it.
        add_item(16'd0, 16'd1000, 32'd21002, -16'sd32767, 16'sd0, 16'sd0, 16'sd1);
        add_item(16'd0, 16'd1000, 32'd1021002, -16'sd32716, 16'sd0, 16'sd0, 16'sd1);
        // Most negative normal with z at zero, then a timestamp wrap.
        add_item(16'd0, 16'd1000, 32'hFFFF_FFF0, -16'sd32716, -16'sd32768, 16'sd0, 16'sd0);
        add_item(16'd0, 16'd1000, 32'h0000_0010, -16'sd32000, 16'sd1000, -16'sd20000, -16'sd5);
        // Equal axes go forward; right exactly at its deadzone drives nothing.
        add_item(16'd0, 16'd1000, 32'h0001_0010, -16'sd32000, 16'sd5000, -16'sd5000, 16'sd1);
        add_item(16'd0, 16'd1000, 32'h0002_0010, -16'sd31990, 16'sd1638, 16'sd0, 16'sd1);
        add_item(16'd0, 16'd1000, 32'h0003_0010, -16'sd31990, 16'sd0, 16'sd1639, 16'sd1);
        add_item(16'd0, 16'd1000, 32'h0004_0010, -16'sd100, 16'sd0, -16'sd32768, -16'sd1);
        add_item(16'd0, 16'd1000, 32'h0005_0010, 16'sd0, -16'sd32768, 16'sd0, 16'sh7FFF);
        add_item(16'd0, 16'd1000, 32'h8005_0010, 16'sd5, 16'sh7FFF, 16'sd0, -16'sd32768);
        add_item(16'd0, 16'd1000, 32'h8006_0010, 16'sd5, 16'sd0, 16'sd0, 16'sd1);
        repeat (200) measurement_queue.push_back(gen_measurement());
        wait_idle();

        // Largest gains, no deadzones, almost everything passes; no idling here.
        calm = 1'b1;
        cfg_write(pgvm_pkg::REG_CURV_LIMIT, 32'h0000_FFFF);
        cfg_write(pgvm_pkg::REG_MIN_POINTS, 32'h0000_0000);
        cfg_write(pgvm_pkg::REG_PLANE_GAIN, 32'h0000_FFFF);
        cfg_write(pgvm_pkg::REG_VERTICAL_GAIN, 32'h0000_FFFF);
        cfg_write(pgvm_pkg::REG_UP_BOOST, 32'h0000_FFFF);
        cfg_write(pgvm_pkg::REG_X_DEADZONE, 32'h0000_0000);
        cfg_write(pgvm_pkg::REG_Y_DEADZONE, 32'h0000_0000);
        cfg_write(pgvm_pkg::REG_RATE_DEADZONE, 32'h0000_0000);
        repeat (150) measurement_queue.push_back(gen_measurement());
        wait_idle();

        // Widest deadzones and no upward boost.
        calm = 1'b0;
        cfg_write(pgvm_pkg::REG_UP_BOOST, 32'h0000_0000);
        cfg_write(pgvm_pkg::REG_X_DEADZONE, 32'hFFFF_FFFF);
        cfg_write(pgvm_pkg::REG_Y_DEADZONE, 32'hFFFF_FFFF);
        cfg_write(pgvm_pkg::REG_RATE_DEADZONE, 32'hFFFF_FFFF);
        add_item(16'd0, 16'd10, 32'd7000, 16'sd0, -16'sd32768, 16'sd0, 16'sd1);
        add_item(16'd0, 16'd10, 32'd7001, -16'sd32768, 16'sd0, -16'sd32768, -16'sd1);
        add_item(16'd0, 16'd10, 32'd7002, 16'sh7FFF, 16'sd0, -16'sd32768, 16'sd1);
        gen_stamp = 32'd8000;
        gen_alt   = '0;
        repeat (80) measurement_queue.push_back(gen_measurement());
        wait_idle();

        // Nothing can pass.
        cfg_write(pgvm_pkg::REG_CURV_LIMIT, 32'h0000_0000);
        cfg_write(pgvm_pkg::REG_MIN_POINTS, 32'h0000_FFFF);
        repeat (15) measurement_queue.push_back(gen_measurement());
        wait_idle();

        // No gain at all, small boost, no deadzones.
        cfg_write(pgvm_pkg::REG_CURV_LIMIT, 32'h0000_FFFF);
        cfg_write(pgvm_pkg::REG_MIN_POINTS, 32'h0000_0000);
        cfg_write(pgvm_pkg::REG_PLANE_GAIN, 32'h0000_0000);
        cfg_write(pgvm_pkg::REG_VERTICAL_GAIN, 32'h0000_0000);
        cfg_write(pgvm_pkg::REG_UP_BOOST, 32'h0000_0001);
        cfg_write(pgvm_pkg::REG_X_DEADZONE, 32'h0000_0000);
        cfg_write(pgvm_pkg::REG_Y_DEADZONE, 32'h0000_0000);
        cfg_write(pgvm_pkg::REG_RATE_DEADZONE, 32'h0000_0000);
        repeat (60) measurement_queue.push_back(gen_measurement());
        wait_idle();

        // Random settings that still let most measurements through.
        for (int k = 0; k < 2; k++)
        begin
            cfg_write(pgvm_pkg::REG_CURV_LIMIT, $urandom_range(1000, 65535));
            cfg_write(pgvm_pkg::REG_MIN_POINTS, $urandom_range(0, 2000));
            cfg_write(pgvm_pkg::REG_PLANE_GAIN, $urandom);
            cfg_write(pgvm_pkg::REG_VERTICAL_GAIN, $urandom);
            cfg_write(pgvm_pkg::REG_UP_BOOST, $urandom);
            cfg_write(pgvm_pkg::REG_X_DEADZONE, $urandom_range(0, 3000));
            cfg_write(pgvm_pkg::REG_Y_DEADZONE, $urandom_range(0, 3000));
            cfg_write(pgvm_pkg::REG_RATE_DEADZONE, $urandom_range(0, 3000));
            repeat (120) measurement_queue.push_back(gen_measurement());
            wait_idle();
        end

        repeat (100) @(posedge clk);
        if (error_count == 0 && expected_commands.size() == 0)
            $display("** plane_gesture_velocity_mapper: PASSED **");
        else
            $display("** plane_gesture_velocity_mapper: FAILED **");
        $finish;
    end

endmodule
